### rtl/core/ptw_pkg.sv
// Shared types and constants for the four-level page table walker.
// Depends on nothing; imported by every module of the walker.
`default_nettype none

package ptw_pkg;

   // Geometry of the table store.
   localparam int DEFAULT_NUM_TABLES = 64;
   localparam int ENTRIES_PER_TABLE  = 512;
   localparam int IDX_W              = 9;
   localparam int FRAME_W            = 40;
   localparam int ENTRY_W            = 64;
   localparam int VA_W               = 48;
   localparam int PA_W               = 52;

   // Request commands.
   localparam logic [1:0] CMD_MAP    = 2'd0;
   localparam logic [1:0] CMD_LOOKUP = 2'd1;
   localparam logic [1:0] CMD_UNMAP  = 2'd2;

   // Response status codes.
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_NOT_MAPPED = 2'd1;
   localparam logic [1:0] ST_FULL       = 2'd2;

   // Walk level of the leaf table (PT).
   localparam logic [1:0] LVL_PT = 2'd3;

   // Low attribute bits of a link entry: present, writable, user.
   localparam logic [11:0] LINK_ATTR = 12'h007;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load_req;
      logic       init_step;
      logic       rd_issue;
      logic       set_cur_link;
      logic       clr_step;
      logic       wr_link;
      logic       wr_leaf;
      logic       wr_unmap;
      logic       set_res;
      logic [1:0] res_status;
      logic       res_frame;
      logic       load_rsp;
   } ptw_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] command;
      logic       present;
      logic       link_ok;
      logic       tables_full;
      logic       lvl_last;
      logic       clr_last;
      logic       init_last;
   } ptw_stat_type;

endpackage

`default_nettype wire

### rtl/core/four_level_page_table_walker.sv
// Four-level page table walker: top level joining controller and datapath.
// Depends on ptw_pkg, ptw_controller and ptw_datapath.
//
// The walker keeps NUM_TABLES page tables of 512 64-bit entries in one internal
// single-port-write memory and serves map, lookup and unmap requests, one at a time,
// with one response each. After reset the whole store is cleared, one entry per
// cycle; no request is taken until then, while base frame writes are always
// taken. Each table level is a memory read (S_READ) and its evaluation (S_EVAL);
// after the last level the response is loaded in S_DONE, and the walker then
// returns to S_IDLE to take another request. A walk that stops early, or an unused
// command, answers sooner. Each table that a map allocates adds the clear of its
// 512 entries (S_CLEAR) and the link write (S_LINK) to the walk.
// The next request is taken while a response still waits for its consumer; its own
// response is held until the older one has left.
`default_nettype none

module four_level_page_table_walker #(
   parameter int NUM_TABLES = ptw_pkg::DEFAULT_NUM_TABLES
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_valid,
   output      logic                        csr_ready,
   input  wire logic [ptw_pkg::FRAME_W-1:0] csr_table_base_frame,
   input  wire logic                        req_valid,
   output      logic                        req_ready,
   input  wire logic [1:0]                  req_command,
   input  wire logic [ptw_pkg::VA_W-1:0]    req_virt_addr,
   input  wire logic [ptw_pkg::PA_W-1:0]    req_phys_addr,
   input  wire logic                        req_writable,
   input  wire logic                        req_user_access,
   input  wire logic                        req_executable,
   output      logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   output      logic [1:0]                  rsp_status,
   output      logic [ptw_pkg::PA_W-1:0]    rsp_frame_addr
);
   import ptw_pkg::*;

   ptw_cmd_type  cmd;
   ptw_stat_type stat;

   // The base frame register takes every write at once.
   assign csr_ready = 1'b1;

   ptw_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .stat      (stat),
      .cmd       (cmd),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready)
   );

   ptw_datapath #(
      .NUM_TABLES (NUM_TABLES)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .csr_valid            (csr_valid),
      .csr_table_base_frame (csr_table_base_frame),
      .req_command          (req_command),
      .req_virt_addr        (req_virt_addr),
      .req_phys_addr        (req_phys_addr),
      .req_writable         (req_writable),
      .req_user_access      (req_user_access),
      .req_executable       (req_executable),
      .rsp_status           (rsp_status),
      .rsp_frame_addr       (rsp_frame_addr)
   );

endmodule

`default_nettype wire

### rtl/core/ptw_datapath.sv
// Datapath of the page table walker: table store, walk registers and result registers.
// Depends on ptw_pkg; driven by ptw_controller.
`default_nettype none

module ptw_datapath #(
   parameter int NUM_TABLES = ptw_pkg::DEFAULT_NUM_TABLES
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ptw_pkg::ptw_cmd_type          cmd,
   output      ptw_pkg::ptw_stat_type         stat,
   input  wire logic                          csr_valid,
   input  wire logic [ptw_pkg::FRAME_W-1:0]   csr_table_base_frame,
   input  wire logic [1:0]                    req_command,
   input  wire logic [ptw_pkg::VA_W-1:0]      req_virt_addr,
   input  wire logic [ptw_pkg::PA_W-1:0]      req_phys_addr,
   input  wire logic                          req_writable,
   input  wire logic                          req_user_access,
   input  wire logic                          req_executable,
   output      logic [1:0]                    rsp_status,
   output      logic [ptw_pkg::PA_W-1:0]      rsp_frame_addr
);
   import ptw_pkg::*;

   localparam int TBL_W  = $clog2(NUM_TABLES);
   localparam int NF_W   = $clog2(NUM_TABLES + 1);
   localparam int MEM_AW = TBL_W + IDX_W;
   localparam int DEPTH  = NUM_TABLES * ENTRIES_PER_TABLE;

   // Table store.
   logic [ENTRY_W-1:0] mem [DEPTH];

   // Configuration.
   logic [FRAME_W-1:0] base_ff;

   // Latched request.
   logic [1:0]         command_ff;
   logic [VA_W-1:0]    va_ff;
   logic [PA_W-1:0]    pa_ff;
   logic               writable_ff, user_ff, exec_ff;

   // Walk state.
   logic [TBL_W-1:0]   cur_ff, cur_in;
   logic [1:0]         lvl_ff, lvl_in;
   logic [NF_W-1:0]    next_free_ff, next_free_in;
   logic [IDX_W-1:0]   clr_cnt_ff, clr_cnt_in;
   logic [MEM_AW-1:0]  init_cnt_ff, init_cnt_in;
   logic [ENTRY_W-1:0] rd_data_ff;

   // Results.
   logic [1:0]         res_status_ff;
   logic [PA_W-1:0]    res_frame_ff;
   logic [1:0]         rsp_status_ff;
   logic [PA_W-1:0]    rsp_frame_ff;

   logic [IDX_W-1:0]   idx;
   logic [TBL_W-1:0]   fresh;
   logic [FRAME_W-1:0] link_frame;
   logic [FRAME_W-1:0] fresh_frame;
   logic               we;
   logic [MEM_AW-1:0]  wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [ENTRY_W-1:0] leaf_entry;

   // Index for the current level.
   always_comb begin
      unique case (lvl_ff)
         2'd0:    idx = va_ff[47:39];
         2'd1:    idx = va_ff[38:30];
         2'd2:    idx = va_ff[29:21];
         default: idx = va_ff[20:12];
      endcase
   end

   assign fresh       = next_free_ff[TBL_W-1:0];
   assign link_frame  = rd_data_ff[51:12] - base_ff;
   assign fresh_frame = base_ff + FRAME_W'(fresh);
   assign leaf_entry  = {~exec_ff, 11'b0, pa_ff[51:12], 9'b0, user_ff, writable_ff, 1'b1};

   // Status toward the controller.
   always_comb begin
      stat.command     = command_ff;
      stat.present     = rd_data_ff[0];
      stat.link_ok     = (link_frame < FRAME_W'(NUM_TABLES));
      stat.tables_full = (next_free_ff >= NF_W'(NUM_TABLES));
      stat.lvl_last    = (lvl_ff == LVL_PT);
      stat.clr_last    = (clr_cnt_ff == IDX_W'(ENTRIES_PER_TABLE - 1));
      stat.init_last   = (init_cnt_ff == MEM_AW'(DEPTH - 1));
   end

   // Single write port select.
   always_comb begin
      we      = 1'b0;
      wr_addr = {cur_ff, idx};
      wr_data = '0;
      priority if (cmd.init_step) begin
         we      = 1'b1;
         wr_addr = init_cnt_ff;
      end else if (cmd.clr_step) begin
         we      = 1'b1;
         wr_addr = {fresh, clr_cnt_ff};
      end else if (cmd.wr_link) begin
         we      = 1'b1;
         wr_data = {12'b0, fresh_frame, LINK_ATTR};
      end else if (cmd.wr_leaf) begin
         we      = 1'b1;
         wr_data = leaf_entry;
      end else if (cmd.wr_unmap) begin
         we      = 1'b1;
      end else begin
         we      = 1'b0;
      end
   end

   // Memory write and registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_issue) begin
         rd_data_ff <= mem[{cur_ff, idx}];
      end
   end

   // Next values of the walk counters.
   always_comb begin
      cur_in       = cur_ff;
      lvl_in       = lvl_ff;
      next_free_in = next_free_ff;
      clr_cnt_in   = clr_cnt_ff;
      init_cnt_in  = init_cnt_ff;
      if (cmd.load_req) begin
         cur_in = '0;
         lvl_in = '0;
      end
      if (cmd.set_cur_link) begin
         cur_in = link_frame[TBL_W-1:0];
         lvl_in = lvl_ff + 2'd1;
      end
      if (cmd.wr_link) begin
         cur_in       = fresh;
         lvl_in       = lvl_ff + 2'd1;
         next_free_in = next_free_ff + NF_W'(1);
      end
      if (cmd.clr_step) begin
         clr_cnt_in = clr_cnt_ff + IDX_W'(1);
      end
      if (cmd.init_step) begin
         init_cnt_in = init_cnt_ff + MEM_AW'(1);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         next_free_ff <= NF_W'(1);
         clr_cnt_ff   <= '0;
         init_cnt_ff  <= '0;
         cur_ff       <= '0;
         lvl_ff       <= '0;
      end else begin
         if (csr_valid) begin
            base_ff <= csr_table_base_frame;
         end
         next_free_ff <= next_free_in;
         clr_cnt_ff   <= clr_cnt_in;
         init_cnt_ff  <= init_cnt_in;
         cur_ff       <= cur_in;
         lvl_ff       <= lvl_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         command_ff  <= req_command;
         va_ff       <= req_virt_addr;
         pa_ff       <= req_phys_addr;
         writable_ff <= req_writable;
         user_ff     <= req_user_access;
         exec_ff     <= req_executable;
      end
      if (cmd.set_res) begin
         res_status_ff <= cmd.res_status;
         res_frame_ff  <= cmd.res_frame ? {rd_data_ff[51:12], 12'b0} : '0;
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_frame_ff  <= res_frame_ff;
      end
   end

   assign rsp_status     = rsp_status_ff;
   assign rsp_frame_addr = rsp_frame_ff;

endmodule

`default_nettype wire

### rtl/core/ptw_controller.sv
// Controller state machine of the page table walker.
// Depends on ptw_pkg; drives ptw_datapath through command and status structs.
`default_nettype none

module ptw_controller (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ptw_pkg::ptw_stat_type stat,
   output      ptw_pkg::ptw_cmd_type  cmd,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready
);
   import ptw_pkg::*;

   localparam logic [2:0] S_INIT  = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_EVAL  = 3'd3;
   localparam logic [2:0] S_CLEAR = 3'd4;
   localparam logic [2:0] S_LINK  = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_INIT: begin
            cmd.init_step = 1'b1;
            if (stat.init_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_READ;
            end
         end
         S_READ: begin
            // Unused command answers not mapped without touching the store.
            if (stat.command != CMD_MAP && stat.command != CMD_LOOKUP &&
                stat.command != CMD_UNMAP) begin
               cmd.set_res    = 1'b1;
               cmd.res_status = ST_NOT_MAPPED;
               state_in       = S_DONE;
            end else begin
               cmd.rd_issue = 1'b1;
               state_in     = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.set_res = 1'b1;
            state_in    = S_DONE;
            if (!stat.lvl_last) begin
               // Intermediate level: follow, allocate or stop.
               if (stat.present) begin
                  if (stat.link_ok) begin
                     cmd.set_res      = 1'b0;
                     cmd.set_cur_link = 1'b1;
                     state_in         = S_READ;
                  end else begin
                     cmd.res_status = (stat.command == CMD_MAP) ? ST_FULL : ST_NOT_MAPPED;
                  end
               end else if (stat.command != CMD_MAP) begin
                  cmd.res_status = ST_NOT_MAPPED;
               end else if (stat.tables_full) begin
                  cmd.res_status = ST_FULL;
               end else begin
                  cmd.set_res = 1'b0;
                  state_in    = S_CLEAR;
               end
            end else if (stat.command == CMD_MAP) begin
               cmd.wr_leaf    = 1'b1;
               cmd.res_status = ST_OK;
            end else if (stat.present) begin
               cmd.res_status = ST_OK;
               cmd.res_frame  = 1'b1;
               cmd.wr_unmap   = (stat.command == CMD_UNMAP);
            end else begin
               cmd.res_status = ST_NOT_MAPPED;
            end
         end
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = S_LINK;
            end
         end
         S_LINK: begin
            cmd.wr_link = 1'b1;
            state_in    = S_READ;
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

### sim/tb_four_level_page_table_walker.sv
// Testbench for the four-level page table walker: map, lookup and unmap requests
// checked against a predictor of the table store. Depends on ptw_pkg and the walker RTL.
`timescale 1ns / 100ps

module tb_four_level_page_table_walker;
   import ptw_pkg::*;

   localparam int          TABLE_COUNT   = 64;
   localparam logic [1:0]  CMD_UNUSED    = 2'd3;
   localparam int          STALL_LIMIT   = 200000;
   localparam logic [39:0] BASE_MAX      = 40'hFF_FFFF_FFFF;

   typedef struct packed {
      logic [1:0]      status;
      logic [PA_W-1:0] frame_addr;
   } walk_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [FRAME_W-1:0]  csr_table_base_frame = '0;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_command = CMD_MAP;
   logic [VA_W-1:0]     req_virt_addr = '0;
   logic [PA_W-1:0]     req_phys_addr = '0;
   logic                req_writable = 1'b0;
   logic                req_user_access = 1'b0;
   logic                req_executable = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [1:0]          rsp_status;
   logic [PA_W-1:0]     rsp_frame_addr;

   // Predicted table store and allocator state.
   logic [63:0]         page_store [0:TABLE_COUNT*512-1];
   int unsigned         next_table;
   logic [FRAME_W-1:0]  base_frame;

   walk_result_type     pending_results [$];
   logic [VA_W-1:0]     mapped_vas [$];
   int                  error_count = 0;
   bit                  no_idle = 1'b0;
   int                  stall_cycles = 0;

   four_level_page_table_walker #(.NUM_TABLES(TABLE_COUNT)) dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_table_base_frame(csr_table_base_frame),
      .req_valid(req_valid), .req_ready(req_ready), .req_command(req_command),
      .req_virt_addr(req_virt_addr), .req_phys_addr(req_phys_addr),
      .req_writable(req_writable), .req_user_access(req_user_access),
      .req_executable(req_executable),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_frame_addr(rsp_frame_addr)
   );

   // 20 ns clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Walks PML4, PDPT and PD; returns the status and the PT table number.
   function automatic logic [1:0] walk_to_pt(input logic [VA_W-1:0] va, input bit alloc,
                                             output int unsigned pt);
      int unsigned        cur;
      int unsigned        fresh;
      int unsigned        slot_idx;
      int                 sh;
      logic [63:0]        e;
      logic [FRAME_W-1:0] k;
      cur = 0;
      pt = 0;
      for (int lvl = 0; lvl < 3; lvl++) begin
         sh = 39 - 9 * lvl;
         slot_idx = cur * 512 + va[sh +: 9];
         e = page_store[slot_idx];
         if (!e[0]) begin
            if (!alloc) return ST_NOT_MAPPED;
            if (next_table >= TABLE_COUNT) return ST_FULL;
            fresh = next_table;
            next_table++;
            for (int i = 0; i < 512; i++) page_store[fresh * 512 + i] = '0;
            e = {12'h000, base_frame + FRAME_W'(fresh), LINK_ATTR};
            page_store[slot_idx] = e;
         end
         // A link outside the store's frame window stops the walk.
         k = e[51:12] - base_frame;
         if (k >= TABLE_COUNT) return alloc ? ST_FULL : ST_NOT_MAPPED;
         cur = k[31:0];
      end
      pt = cur;
      return ST_OK;
   endfunction

   // Applies one request to the predicted store and returns its response.
   function automatic walk_result_type predict_walk(input logic [1:0] cmd,
         input logic [VA_W-1:0] va, input logic [PA_W-1:0] pa,
         input logic wr, input logic us, input logic ex);
      walk_result_type r;
      int unsigned     pt;
      int unsigned     leaf_slot;
      logic [63:0]     e;
      r.status = ST_NOT_MAPPED;
      r.frame_addr = '0;
      if (cmd == CMD_MAP) begin
         r.status = walk_to_pt(va, 1'b1, pt);
         if (r.status == ST_OK)
            page_store[pt * 512 + va[20:12]] =
               {!ex, 11'h000, pa[51:12], 9'h000, us, wr, 1'b1};
      end else if (cmd == CMD_LOOKUP || cmd == CMD_UNMAP) begin
         r.status = walk_to_pt(va, 1'b0, pt);
         if (r.status == ST_OK) begin
            leaf_slot = pt * 512 + va[20:12];
            e = page_store[leaf_slot];
            if (e[0]) begin
               r.frame_addr = {e[51:12], 12'h000};
               if (cmd == CMD_UNMAP) page_store[leaf_slot] = '0;
            end else begin
               r.status = ST_NOT_MAPPED;
            end
         end
      end
      return r;
   endfunction

   // Sends one request, holding it until accepted; may idle before it.
   task automatic send_request(input logic [1:0] cmd, input logic [VA_W-1:0] va,
                               input logic [PA_W-1:0] pa, input logic wr,
                               input logic us, input logic ex);
      if (!no_idle && $urandom_range(0, 99) < 20) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_virt_addr   <= va;
      req_phys_addr   <= pa;
      req_writable    <= wr;
      req_user_access <= us;
      req_executable  <= ex;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(predict_walk(cmd, va, pa, wr, us, ex));
   endtask

   // Waits until every response is in, then writes the base frame.
   task automatic write_base_frame(input logic [FRAME_W-1:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      csr_valid            <= 1'b1;
      csr_table_base_frame <= value;
      do @(posedge clock); while (!csr_ready);
      base_frame = value;
      csr_valid <= 1'b0;
   endtask

   // Response check, with random back-pressure.
   always @(posedge clock) begin
      walk_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $display("%t unexpected response: status %0d frame %h", $time,
                        rsp_status, rsp_frame_addr);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%t status mismatch: expected %0d, actual %0d", $time,
                           want.status, rsp_status);
                  error_count++;
               end
               if (rsp_frame_addr !== want.frame_addr) begin
                  $display("%t frame_addr mismatch: expected %h, actual %h", $time,
                           want.frame_addr, rsp_frame_addr);
                  error_count++;
               end
            end
         end
         rsp_ready <= no_idle || ($urandom_range(0, 99) >= 20);
      end
   end

   // Watchdog on cycles with no handshake at all.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb_four_level_page_table_walker: errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic logic [PA_W-1:0] random_pa();
      return PA_W'({$urandom, $urandom});
   endfunction

   // Mostly addresses in a small cluster of tables, sometimes anywhere.
   function automatic logic [VA_W-1:0] random_va();
      logic [VA_W-1:0] va;
      va = VA_W'({$urandom, $urandom});
      if ($urandom_range(0, 99) < 80) begin
         va[47:39] = $urandom_range(0, 1) ? 9'h1FF : 9'h000;
         va[38:30] = $urandom_range(0, 1) ? 9'h1FF : 9'h000;
         va[29:21] = $urandom_range(0, 1) ? 9'h1FF : 9'h000;
      end
      return va;
   endfunction

   // Corner cases: extremes of every field, every command, missing entries.
   task automatic test_directed();
      send_request(CMD_LOOKUP, '0, '0, 1'b0, 1'b0, 1'b0);
      send_request(CMD_UNMAP, '0, '0, 1'b0, 1'b0, 1'b0);
      send_request(CMD_MAP, '0, '1, 1'b1, 1'b1, 1'b1);
      send_request(CMD_LOOKUP, 48'h0000_0000_0FFF, '0, 1'b0, 1'b0, 1'b0);
      // Leaf with P clear inside an existing PT.
      send_request(CMD_LOOKUP, 48'h0000_0000_1000, '0, 1'b0, 1'b0, 1'b0);
      send_request(CMD_MAP, '0, 52'h0_0000_1234_5678, 1'b0, 1'b0, 1'b0);
      send_request(CMD_UNMAP, '0, '0, 1'b1, 1'b1, 1'b1);
      send_request(CMD_LOOKUP, '0, '0, 1'b0, 1'b0, 1'b0);
      send_request(CMD_MAP, '1, '0, 1'b0, 1'b0, 1'b0);
      send_request(CMD_LOOKUP, '1, '1, 1'b1, 1'b1, 1'b1);
      send_request(CMD_MAP, 48'h8000_0000_0000, '1, 1'b1, 1'b0, 1'b1);
      send_request(CMD_UNMAP, 48'h8000_0000_0000, '0, 1'b0, 1'b0, 1'b0);
      send_request(CMD_UNUSED, '1, '1, 1'b1, 1'b1, 1'b1);
      send_request(CMD_LOOKUP, '1, '0, 1'b0, 1'b0, 1'b0);
   endtask

   // Random traffic; lookups and unmaps mostly target addresses of earlier map requests.
   task automatic test_random(input int count);
      logic [1:0]      cmd;
      logic [VA_W-1:0] va;
      int              pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) cmd = CMD_MAP;
         else if (pick < 70) cmd = CMD_LOOKUP;
         else if (pick < 95) cmd = CMD_UNMAP;
         else cmd = CMD_UNUSED;
         if (cmd != CMD_MAP && mapped_vas.size() != 0 && $urandom_range(0, 99) < 70)
            va = mapped_vas[$urandom_range(0, mapped_vas.size() - 1)];
         else
            va = random_va();
         if (cmd == CMD_MAP) begin
            if (mapped_vas.size() >= 256) void'(mapped_vas.pop_front());
            mapped_vas.push_back(va);
         end
         send_request(cmd, va, random_pa(), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
   endtask

   // Moves the table window, breaking and restoring existing links.
   task automatic test_base_frames();
      write_base_frame(FRAME_W'({$urandom, $urandom}));
      test_random(300);
      write_base_frame(BASE_MAX);
      test_random(300);
      write_base_frame('0);
      test_random(450);
   endtask

   initial begin
      for (int i = 0; i < TABLE_COUNT * 512; i++) page_store[i] = '0;
      next_table = 1;
      base_frame = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      write_base_frame('0);
      test_directed();
      no_idle = 1'b1;
      test_random(150);
      no_idle = 1'b0;
      test_random(500);
      test_base_frames();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0)
         $display("tb_four_level_page_table_walker: clean");
      else
         $display("tb_four_level_page_table_walker: errors");
      $finish;
   end

endmodule
